// ===== hdl/lna_pkg.sv =====
// Shared constants and types for the newline line assembler.
// No dependencies. In hdl/, lna_store, lna_drain and the top level refer to this package by scoped names.
package lna_pkg;

	localparam int unsigned STORE_DEPTH_DEF = 64;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] NUL_CODE     = 8'd0;

	// One released result, as it leaves the block.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       empty_line;
		logic       overflowed;
	} lna_result_t;

	// Release request from the write side to the drain sequencer.
	typedef struct packed {
		logic go;
		logic overflow;
	} lna_start_t;

endpackage

// ===== hdl/lna_if.sv =====
// Valid/ready channel interfaces for the newline line assembler.
// No module or package dependencies.
interface lna_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface lna_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic       empty_line;
	logic       overflowed;

	modport source (output valid, output out_byte, output last, output empty_line,
		output overflowed, input ready);
	modport sink (input valid, input out_byte, input last, input empty_line,
		input overflowed, output ready);
endinterface

// ===== hdl/lna_store.sv =====
// Circular byte store: one write port, one read port, registered read data.
// Depends on lna_pkg for the default depth.
module lna_store #(
	parameter int unsigned STORE_DEPTH = lna_pkg::STORE_DEPTH_DEF,
	localparam int unsigned AW = $clog2(STORE_DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/lna_drain.sv =====
// Drain sequencer: reads a released line out of the store and queues results
// in a two-entry output buffer. Depends on lna_pkg and lna_out_if.
module lna_drain #(
	parameter int unsigned STORE_DEPTH = lna_pkg::STORE_DEPTH_DEF,
	localparam int unsigned AW = $clog2(STORE_DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lna_pkg::lna_start_t start,
	input  logic [AW-1:0]       start_count,
	output logic                idle,
	output logic                rd_en,
	output logic [AW-1:0]       rd_addr,
	input  logic [7:0]          rd_data,
	lna_out_if.source           out_ch
);

	logic [AW-1:0]        remain_q;
	logic [AW-1:0]        rd_idx_q;
	logic                 ovf_q;
	logic                 inflight_s1;
	logic                 last_s1;
	logic [1:0]           cnt_q;
	lna_pkg::lna_result_t ent0_q;
	lna_pkg::lna_result_t ent1_q;

	logic                 pop;
	logic                 push;
	logic                 issue;
	logic                 start_empty;
	logic [2:0]           occ;
	logic [1:0]           slot;
	lna_pkg::lna_result_t push_data;

	assign pop         = (cnt_q != 2'd0) && out_ch.ready;
	assign occ         = {1'b0, cnt_q} + {2'b00, inflight_s1};
	// Keep buffered plus in-flight results within the two buffer slots.
	assign issue       = (remain_q != '0) && (occ < (3'd2 + {2'b00, pop}));
	assign start_empty = start.go && (start_count == '0);
	assign push        = inflight_s1 || start_empty;
	assign slot        = cnt_q - {1'b0, pop};

	always_comb begin
		if (inflight_s1) begin
			push_data.out_byte   = rd_data;
			push_data.last       = last_s1;
			push_data.empty_line = 1'b0;
			push_data.overflowed = ovf_q;
		end else begin
			push_data.out_byte   = lna_pkg::NUL_CODE;
			push_data.last       = 1'b1;
			push_data.empty_line = 1'b1;
			push_data.overflowed = start.overflow;
		end
	end

	assign rd_en   = issue;
	assign rd_addr = rd_idx_q;
	assign idle    = (remain_q == '0) && !inflight_s1 && (cnt_q != 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q    <= '0;
			rd_idx_q    <= '0;
			ovf_q       <= 1'b0;
			inflight_s1 <= 1'b0;
			last_s1     <= 1'b0;
			cnt_q       <= 2'd0;
		end else begin
			inflight_s1 <= issue;
			cnt_q       <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (start.go && (start_count != '0)) begin
				remain_q <= start_count;
				ovf_q    <= start.overflow;
			end else if (issue) begin
				remain_q <= remain_q - 1'b1;
			end
			if (issue) begin
				last_s1  <= (remain_q == AW'(1));
				rd_idx_q <= (rd_idx_q == AW'(STORE_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
			end
		end
	end

	// Drop the new result into the first free slot, else advance the buffer on pop.
	always_ff @(posedge clk) begin
		if (push && (slot == 2'd0)) begin
			ent0_q <= push_data;
		end else if (pop) begin
			ent0_q <= ent1_q;
		end
		if (push && (slot != 2'd0)) begin
			ent1_q <= push_data;
		end
	end

	assign out_ch.valid      = (cnt_q != 2'd0);
	assign out_ch.out_byte   = ent0_q.out_byte;
	assign out_ch.last       = ent0_q.last;
	assign out_ch.empty_line = ent0_q.empty_line;
	assign out_ch.overflowed = ent0_q.overflowed;

endmodule

// ===== hdl/newline_line_assembler_top.sv =====
// Top level of the newline line assembler: write-side control, byte store and drain.
// Depends on lna_pkg, lna_if (lna_in_if, lna_out_if), lna_store and lna_drain.

// Received bytes enter on rx, one transaction each, and are appended to a circular
// store of STORE_DEPTH bytes that holds at most STORE_DEPTH - 1 pending bytes.
// Zero bytes are dropped. A byte that arrives while the store is full is dropped and
// the next released line carries overflowed on every result. A newline (10) releases
// the pending line on the lines channel, oldest byte first, last set on the final
// byte; a newline with nothing pending gives one result with empty_line set.
// Ordinary bytes stream in at one per clock while the drain is idle and a result slot
// is free. A newline that releases N bytes holds rx off while the drain reads the
// store through its single port with registered read data, one byte per cycle while
// lines keeps taking results and slower under backpressure. Results sit in a two-entry
// output buffer, so rx reopens while one result may still wait to be taken. The store
// needs no clearing pass after reset; only written entries are read.
module newline_line_assembler_top #(
	parameter int unsigned STORE_DEPTH = lna_pkg::STORE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	lna_in_if.sink    rx,
	lna_out_if.source lines
);

	localparam int unsigned AW = $clog2(STORE_DEPTH);

	logic [AW-1:0]       wr_idx_q;
	logic [AW-1:0]       pend_q;
	logic                ovf_q;

	logic                drain_idle;
	logic                acc;
	logic                is_nl;
	logic                is_nul;
	logic                full;
	logic                wr_en;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [7:0]          rd_data;
	lna_pkg::lna_start_t start;

	// Take a byte only while no line is being read out and a result slot is free.
	assign rx.ready = drain_idle;
	assign acc      = rx.valid && rx.ready;
	assign is_nl    = (rx.in_byte == lna_pkg::NEWLINE_CODE);
	assign is_nul   = (rx.in_byte == lna_pkg::NUL_CODE);
	assign full     = (pend_q == AW'(STORE_DEPTH - 1));
	assign wr_en    = acc && !is_nl && !is_nul && !full;

	assign start.go       = acc && is_nl;
	assign start.overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= '0;
			pend_q   <= '0;
			ovf_q    <= 1'b0;
		end else begin
			if (wr_en) begin
				wr_idx_q <= (wr_idx_q == AW'(STORE_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
				pend_q   <= pend_q + 1'b1;
			end
			// Full store: drop the byte and remember it for the next line.
			if (acc && !is_nl && !is_nul && full) begin
				ovf_q <= 1'b1;
			end
			// Newline hands the whole pending line to the drain.
			if (start.go) begin
				pend_q <= '0;
				ovf_q  <= 1'b0;
			end
		end
	end

	lna_store #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_idx_q),
		.wr_data(rx.in_byte),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	lna_drain #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_drain (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.start_count(pend_q),
		.idle       (drain_idle),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.out_ch     (lines)
	);

`ifndef ASSERT_OFF
	a_no_wr_during_rd: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("store written while a line is being read");

	a_nl_clears: assert property (@(posedge clk) disable iff (!arst_n)
		start.go |=> (pend_q == '0) && !ovf_q)
		else $error("pending line not cleared after newline");

	a_nl_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(start.go && (pend_q != '0)) |=> !rx.ready)
		else $error("input accepted while a line is being released");

	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr_en)
		else $error("write into a full store");
`endif

endmodule

// ===== tb/tb_newline_line_assembler_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for newline_line_assembler_top: directed table, then random lines.
// Depends on lna_pkg, lna_if (lna_in_if, lna_out_if) and the block's RTL.
module tb_newline_line_assembler_top;

	localparam int unsigned DEPTH       = lna_pkg::STORE_DEPTH_DEF;
	localparam int unsigned IDX_W       = $clog2(DEPTH);
	localparam int unsigned RAND_ITEMS  = 24;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned SETTLE      = 40;
	localparam int unsigned TIMEOUT_NS  = 2_000_000;

	// One row of the directed table. A typed row carries its own expectation (how many
	// results, and the value they all share); every other row goes through the line predictor.
	typedef struct packed {
		logic [7:0]           in_byte;
		int unsigned          reps;
		bit                   typed;
		int unsigned          typed_n;
		lna_pkg::lna_result_t typed_res;
	} stim_row_t;

	localparam lna_pkg::lna_result_t NO_RES    = '0;
	localparam lna_pkg::lna_result_t EMPTY_RES = '{out_byte: lna_pkg::NUL_CODE, last: 1'b1,
		empty_line: 1'b1, overflowed: 1'b0};
	localparam lna_pkg::lna_result_t FF_RES    = '{out_byte: 8'hFF, last: 1'b1,
		empty_line: 1'b0, overflowed: 1'b0};
	localparam lna_pkg::lna_result_t ONE_RES   = '{out_byte: 8'h01, last: 1'b1,
		empty_line: 1'b0, overflowed: 1'b0};

	logic clk = 1'b0;
	logic arst_n;

	lna_in_if  rx_if ();
	lna_out_if lines_if ();

	newline_line_assembler_top #(
		.STORE_DEPTH(DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_if.sink),
		.lines (lines_if.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: our own copy of the byte ring and its bookkeeping.
	logic [7:0]       byte_store [DEPTH];
	logic [IDX_W-1:0] store_wr      = '0;
	logic [IDX_W-1:0] store_rd      = '0;
	logic [IDX_W:0]   store_fill    = '0;
	bit               store_dropped = 1'b0;

	lna_pkg::lna_result_t line_scratch_q [$];
	lna_pkg::lna_result_t line_expect_q [$];

	int unsigned fail_count    = 0;
	int unsigned results_taken = 0;
	int unsigned burst_left    = 1;
	bit          offer_high    = 1'b0;

	// Table walked first: extremes, zero bytes, empty lines, an exactly full store,
	// an overflowing line, and enough traffic to wrap both ring pointers.
	stim_row_t directed_rows [26] = '{
		'{lna_pkg::NEWLINE_CODE, 1, 1'b1, 1, EMPTY_RES},  // empty line straight out of reset
		'{lna_pkg::NUL_CODE,     1, 1'b1, 0, NO_RES},
		'{lna_pkg::NEWLINE_CODE, 1, 1'b1, 1, EMPTY_RES},
		'{8'hFF,                 1, 1'b1, 0, NO_RES},
		'{lna_pkg::NEWLINE_CODE, 1, 1'b1, 1, FF_RES},
		'{8'h01,                 1, 1'b1, 0, NO_RES},
		'{lna_pkg::NEWLINE_CODE, 1, 1'b1, 1, ONE_RES},
		'{8'h41,                 1, 1'b0, 0, NO_RES},
		'{lna_pkg::NUL_CODE,     1, 1'b0, 0, NO_RES},     // zero byte in the middle of a line
		'{8'h42,                 1, 1'b0, 0, NO_RES},
		'{lna_pkg::NEWLINE_CODE, 1, 1'b0, 0, NO_RES},
		'{8'h55,                 1, 1'b0, 0, NO_RES},
		'{8'hAA,                 1, 1'b0, 0, NO_RES},
		'{8'h0B,                 1, 1'b0, 0, NO_RES},     // neighbors of the newline code
		'{8'h09,                 1, 1'b0, 0, NO_RES},
		'{8'h80,                 1, 1'b0, 0, NO_RES},
		'{8'h7F,                 1, 1'b0, 0, NO_RES},
		'{lna_pkg::NEWLINE_CODE, 1, 1'b0, 0, NO_RES},
		'{8'h6D,         DEPTH - 1, 1'b0, 0, NO_RES},     // store exactly full, no drop
		'{lna_pkg::NEWLINE_CODE, 1, 1'b0, 0, NO_RES},
		'{8'h6F,         DEPTH + 1, 1'b0, 0, NO_RES},     // overrun the store
		'{lna_pkg::NUL_CODE,     1, 1'b0, 0, NO_RES},
		'{lna_pkg::NEWLINE_CODE, 1, 1'b0, 0, NO_RES},     // whole line flagged overflowed
		'{lna_pkg::NEWLINE_CODE, 1, 1'b1, 1, EMPTY_RES},  // flag must be gone again
		'{8'h77,                 8, 1'b0, 0, NO_RES},     // short line after both pointers have wrapped
		'{lna_pkg::NEWLINE_CODE, 1, 1'b0, 0, NO_RES}
	};

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		$display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		fail_count++;
	endtask

	function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] pos);
		return (pos == DEPTH - 1) ? '0 : pos + 1'b1;
	endfunction

	// Work out the results one received byte causes and leave them in line_scratch_q.
	function automatic void predict_line(input logic [7:0] rx_byte);
		lna_pkg::lna_result_t res;
		line_scratch_q.delete();
		if (rx_byte == lna_pkg::NUL_CODE)
			return;
		if (rx_byte != lna_pkg::NEWLINE_CODE) begin
			// Full store: drop the byte, remember it for the next released line.
			if (store_fill >= DEPTH - 1)
				store_dropped = 1'b1;
			else begin
				byte_store[store_wr] = rx_byte;
				store_wr = next_pos(store_wr);
				store_fill = store_fill + 1'b1;
			end
			return;
		end
		if (store_fill == 0) begin
			res = '{out_byte: lna_pkg::NUL_CODE, last: 1'b1, empty_line: 1'b1,
				overflowed: store_dropped};
			line_scratch_q.push_back(res);
		end
		while (store_fill != 0) begin
			store_fill = store_fill - 1'b1;
			res = '{out_byte: byte_store[store_rd], last: store_fill == 0, empty_line: 1'b0,
				overflowed: store_dropped};
			store_rd = next_pos(store_rd);
			line_scratch_q.push_back(res);
		end
		store_dropped = 1'b0;
	endfunction

	// Offer one byte, hold it until the transaction completes, then book its results.
	// Valid stays high across a burst; between most bursts drop it for a random gap.
	task automatic send_byte(input logic [7:0] rx_byte, input bit typed,
		input int unsigned typed_n, input lna_pkg::lna_result_t typed_res);
		int unsigned gap;
		rx_if.valid   <= 1'b1;
		rx_if.in_byte <= rx_byte;
		offer_high = 1'b1;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		predict_line(rx_byte);
		if (typed) begin
			repeat (typed_n)
				line_expect_q.push_back(typed_res);
		end else begin
			foreach (line_scratch_q[k])
				line_expect_q.push_back(line_scratch_q[k]);
		end
		burst_left--;
		if (burst_left == 0) begin
			// A quarter of the bursts run straight into the next one.
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				rx_if.valid <= 1'b0;
				offer_high = 1'b0;
				repeat (gap)
					@(posedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
	endtask

	// Check every result transaction against the oldest expectation, field by field.
	always @(posedge clk) begin
		lna_pkg::lna_result_t want;
		if (arst_n && lines_if.valid && lines_if.ready) begin
			results_taken <= results_taken + 1;
			if (line_expect_q.size() == 0)
				report_mismatch("result with nothing expected", 32'(lines_if.out_byte), 0);
			else begin
				want = line_expect_q.pop_front();
				if (lines_if.out_byte !== want.out_byte)
					report_mismatch("out_byte", 32'(lines_if.out_byte), 32'(want.out_byte));
				if (lines_if.last !== want.last)
					report_mismatch("last", 32'(lines_if.last), 32'(want.last));
				if (lines_if.empty_line !== want.empty_line)
					report_mismatch("empty_line", 32'(lines_if.empty_line),
						32'(want.empty_line));
				if (lines_if.overflowed !== want.overflowed)
					report_mismatch("overflowed", 32'(lines_if.overflowed),
						32'(want.overflowed));
			end
		end
	end

	// Receiver: spans of always-ready, coin-flip, fixed 3-of-4 and mostly-stalled.
	// Once, in the middle of the long directed line, hold off for a long stretch so
	// the output buffer fills and the block has to stall rx.
	initial begin : lines_sink
		int unsigned mode;
		int unsigned span;
		bit          held;
		held = 1'b0;
		lines_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && results_taken >= 20) begin
				held = 1'b1;
				lines_if.ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(5, 40);
				for (int k = 0; k < span; k++) begin
					case (mode)
						0: lines_if.ready <= 1'b1;
						1: lines_if.ready <= 1'($urandom_range(0, 1));
						2: lines_if.ready <= (k % 4) != 3;
						default: lines_if.ready <= ($urandom_range(0, 7) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Reset, directed table, random lines, drain, verdict.
	initial begin : rx_source
		int unsigned rand_items;
		int unsigned kind;
		int unsigned len;
		logic [7:0]  data;
		arst_n = 1'b0;
		rx_if.valid   <= 1'b0;
		rx_if.in_byte <= '0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r])
			repeat (directed_rows[r].reps)
				send_byte(directed_rows[r].in_byte, directed_rows[r].typed,
					directed_rows[r].typed_n, directed_rows[r].typed_res);

		// Mostly well-formed lines with random content; now and then an overrun line,
		// a stray zero byte, a fully random byte, or a line that runs into the next.
		rand_items = 0;
		while (rand_items < RAND_ITEMS) begin
			kind = $urandom_range(0, 15);
			if (kind == 0)
				len = $urandom_range(DEPTH, DEPTH + 12);
			else if (kind <= 2)
				len = $urandom_range(20, DEPTH - 1);
			else
				len = $urandom_range(0, 12);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 15) == 0)
					send_byte(lna_pkg::NUL_CODE, 1'b0, 0, NO_RES);
				if ($urandom_range(0, 31) == 0)
					data = 8'($urandom_range(0, 255));
				else begin
					do
						data = 8'($urandom_range(1, 255));
					while (data == lna_pkg::NEWLINE_CODE);
				end
				send_byte(data, 1'b0, 0, NO_RES);
				if (data != lna_pkg::NUL_CODE)
					rand_items++;
			end
			if ($urandom_range(0, 9) != 0) begin
				send_byte(lna_pkg::NEWLINE_CODE, 1'b0, 0, NO_RES);
				rand_items++;
			end
		end
		// Close the last line so nothing is left pending in the store.
		send_byte(lna_pkg::NEWLINE_CODE, 1'b0, 0, NO_RES);

		if (offer_high)
			rx_if.valid <= 1'b0;
		while (line_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Backstop against a hung handshake.
	initial begin : watchdog
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

endmodule
